### rtl/plti_pkg.sv
// Shared types and constants for the piecewise-linear table interpolator.
// No dependencies; every other file in rtl/ imports this package.
package plti_pkg;

  localparam int DefaultTableDepth = 64;
  localparam int ValueWidth        = 32;
  localparam int CountWidth        = 7;

  typedef enum logic [1:0] {
    RANGE_INSIDE = 2'd0,
    RANGE_BELOW  = 2'd1,
    RANGE_ABOVE  = 2'd2
  } range_code_t;

  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // Divider handshake towards the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### rtl/plti_mem.sv
// Breakpoint store: energy and velocity arrays with one write port and one
// registered read port. Depends on plti_pkg.
module plti_mem
  import plti_pkg::*;
#(
  parameter int TABLE_DEPTH = DefaultTableDepth,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [ValueWidth-1:0] wenergy,
  input  logic [ValueWidth-1:0] wvelocity,
  input  logic [AW-1:0]         raddr,
  output logic [ValueWidth-1:0] renergy,
  output logic [ValueWidth-1:0] rvelocity
);

  logic [ValueWidth-1:0] energy_mem [TABLE_DEPTH];
  logic [ValueWidth-1:0] velocity_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      energy_mem[waddr]   <= wenergy;
      velocity_mem[waddr] <= wvelocity;
    end
  end

  always_ff @(posedge clk) begin
    renergy   <= energy_mem[raddr];
    rvelocity <= velocity_mem[raddr];
  end

endmodule

### rtl/plti_div.sv
// Restoring divider, one quotient bit per cycle: 64-bit dividend by a
// 32-bit divisor. Depends on plti_pkg.
module plti_div
  import plti_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [2*ValueWidth-1:0] dividend,
  input  logic [ValueWidth-1:0]   divisor,
  output logic [2*ValueWidth-1:0] quotient,
  output div_status_t             status
);

  localparam int CW = $clog2(2 * ValueWidth);

  logic [ValueWidth-1:0]   rem;
  logic [ValueWidth-1:0]   dvsr;
  logic [CW-1:0]           count;
  logic                    busy;
  logic                    done;
  logic [ValueWidth:0]     trial;
  logic                    take;

  assign trial = {rem, quotient[2*ValueWidth-1]};
  assign take  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == CW'(2 * ValueWidth - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvsr     <= divisor;
      quotient <= dividend;
      count    <= '0;
    end else if (busy) begin
      // The remainder stays below the divisor, so 32 bits hold it after the subtract.
      rem      <= take ? ValueWidth'(trial - {1'b0, dvsr}) : trial[ValueWidth-1:0];
      quotient <= {quotient[2*ValueWidth-2:0], take};
      count    <= count + 1'b1;
    end
  end

  assign status = '{busy: busy, done: done};

endmodule

### rtl/piecewise_linear_table_interp.sv
// A load (cmd 0) writes one breakpoint. A query (cmd 1) first reads the table
// ends. A query below the first breakpoint, above the last or equal to it is
// answered straight after the check. Otherwise the segment is found either by
// a serial division (when the first and last spacings are equal) or by a scan
// of one breakpoint per cycle; then the segment is read and, unless it does not
// rise, multiplied and passed through a second serial division. The sequencer
// goes back to idle once the result is in the output registers. New beats are
// taken whenever the sequencer is idle, even while a result still waits.
// Depends on plti_pkg, plti_mem and plti_div.
module piecewise_linear_table_interp
  import plti_pkg::*;
#(
  parameter int TABLE_DEPTH = DefaultTableDepth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CountWidth-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  logic [5:0]            point_index,
  input  logic [ValueWidth-1:0] load_energy,
  input  logic [ValueWidth-1:0] load_velocity,
  input  logic [ValueWidth-1:0] query_energy,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ValueWidth-1:0] drift_velocity,
  output logic [1:0]            range_code
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int VW = ValueWidth;

  typedef enum logic [17:0] {
    S_IDLE = 18'd1,
    S_F0   = 18'd2,
    S_F1   = 18'd4,
    S_F2   = 18'd8,
    S_F3   = 18'd16,
    S_CHK  = 18'd32,
    S_UGO  = 18'd64,
    S_UDIV = 18'd128,
    S_SCAN = 18'd256,
    S_SEND = 18'd512,
    S_G0   = 18'd1024,
    S_G1   = 18'd2048,
    S_G2   = 18'd4096,
    S_MUL  = 18'd8192,
    S_SGO  = 18'd16384,
    S_SDIV = 18'd32768,
    S_FIN  = 18'd65536,
    S_OUT  = 18'd131072
  } state_t;

  state_t                state;
  logic [CountWidth-1:0] point_count;
  logic [NW-1:0]         n_used;
  logic [AW-1:0]         last_idx;
  logic [AW-1:0]         pen_idx;
  logic                  in_accept;
  logic [AW-1:0]         slot;
  logic [AW-1:0]         raddr;
  logic [VW-1:0]         e_q;
  logic [VW-1:0]         v_q;

  logic [VW-1:0]         query;
  logic [VW-1:0]         e0;
  logic [VW-1:0]         e1;
  logic [VW-1:0]         en2;
  logic [VW-1:0]         ei;
  logic [VW-1:0]         vi;
  logic [VW-1:0]         ei1;
  logic [VW-1:0]         dv;
  logic [VW-1:0]         dq;
  logic                  neg;
  logic [2*VW-1:0]       prod;
  logic [AW-1:0]         seg;
  logic [AW-1:0]         scan_k;
  logic [AW-1:0]         chk_idx;
  logic                  chk_valid;
  logic [VW-1:0]         res_vel;
  range_code_t           res_code;

  logic                  div_start;
  logic [2*VW-1:0]       div_dividend;
  logic [VW-1:0]         div_divisor;
  logic [2*VW-1:0]       quot;
  div_status_t           div_st;

  logic [VW:0]           first_gap;
  logic [VW:0]           last_gap;
  logic                  uniform;
  logic [VW-1:0]         sat_vel;

  // Breakpoints in use, held to 2..TABLE_DEPTH.
  always_comb begin
    if (point_count < CountWidth'(2)) begin
      n_used = NW'(2);
    end else if (32'(point_count) > 32'(TABLE_DEPTH)) begin
      n_used = NW'(TABLE_DEPTH);
    end else begin
      n_used = NW'(point_count);
    end
  end
  assign last_idx = AW'(n_used - NW'(1));
  assign pen_idx  = AW'(n_used - NW'(2));

  // Load slot: point_index reduced modulo the table depth, one bit a step.
  always_comb begin
    logic [NW:0] rem;
    rem = '0;
    for (int b = 5; b >= 0; b--) begin
      rem = {rem[NW-1:0], point_index[b]};
      if (32'(rem) >= 32'(TABLE_DEPTH)) rem = rem - (NW+1)'(TABLE_DEPTH);
    end
    slot = AW'(rem);
  end

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    unique case (state)
      S_F0:    raddr = '0;
      S_F1:    raddr = AW'(1);
      S_F2:    raddr = pen_idx;
      S_F3:    raddr = last_idx;
      S_SCAN:  raddr = scan_k;
      S_G0:    raddr = seg;
      S_G1:    raddr = seg + AW'(1);
      default: raddr = '0;
    endcase
  end

  plti_mem #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk       (clk),
    .we        (in_accept && cmd == CMD_LOAD),
    .waddr     (slot),
    .wenergy   (load_energy),
    .wvelocity (load_velocity),
    .raddr     (raddr),
    .renergy   (e_q),
    .rvelocity (v_q)
  );

  assign div_start    = (state == S_UGO) || (state == S_SGO);
  assign div_dividend = (state == S_UGO) ? {{VW{1'b0}}, query - e0} : prod;
  assign div_divisor  = (state == S_UGO) ? e1 - e0 : ei1 - ei;

  plti_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quot),
    .status   (div_st)
  );

  // In S_CHK the read port holds the last breakpoint.
  assign first_gap = {1'b0, e1} - {1'b0, e0};
  assign last_gap  = {1'b0, e_q} - {1'b0, en2};
  assign uniform   = (first_gap == last_gap) && (e1 > e0);

  always_comb begin
    if (neg) begin
      sat_vel = (quot > 64'(vi)) ? '0 : VW'(64'(vi) - quot);
    end else begin
      sat_vel = (quot > 64'({VW{1'b1}} - vi)) ? {VW{1'b1}} : VW'(64'(vi) + quot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= CountWidth'(2);
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) point_count <= cfg_data;
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (in_accept && cmd == CMD_QUERY) state <= S_F0;
        S_F0:   state <= S_F1;
        S_F1:   state <= S_F2;
        S_F2:   state <= S_F3;
        S_F3:   state <= S_CHK;
        S_CHK: begin
          priority if (query < e0 || query >= e_q) begin
            state <= S_OUT;
          end else if (uniform) begin
            state <= S_UGO;
          end else begin
            state <= S_SCAN;
          end
        end
        S_UGO:  state <= S_UDIV;
        S_UDIV: if (div_st.done) state <= S_G0;
        S_SCAN: if (scan_k == pen_idx) state <= S_SEND;
        S_SEND: state <= S_G0;
        S_G0:   state <= S_G1;
        S_G1:   state <= S_G2;
        S_G2:   state <= (e_q <= ei) ? S_OUT : S_MUL;
        S_MUL:  state <= S_SGO;
        S_SGO:  state <= S_SDIV;
        S_SDIV: if (div_st.done) state <= S_FIN;
        S_FIN:  state <= S_OUT;
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: query <= query_energy;
      S_F1:   e0 <= e_q;
      S_F2:   e1 <= e_q;
      S_F3:   en2 <= e_q;
      S_CHK: begin
        seg       <= '0;
        scan_k    <= '0;
        chk_valid <= 1'b0;
        res_code  <= RANGE_INSIDE;
        if (query < e0) begin
          res_vel  <= '0;
          res_code <= RANGE_BELOW;
        end else if (query > e_q) begin
          res_vel  <= v_q;
          res_code <= RANGE_ABOVE;
        end else begin
          res_vel <= v_q;
        end
      end
      S_UDIV: begin
        if (div_st.done) begin
          seg <= (quot > 64'(pen_idx)) ? pen_idx : AW'(quot);
        end
      end
      S_SCAN: begin
        // Data for the previously issued address; the last match wins.
        if (chk_valid && e_q <= query) seg <= chk_idx;
        chk_idx   <= scan_k;
        chk_valid <= 1'b1;
        scan_k    <= scan_k + AW'(1);
      end
      S_SEND: if (e_q <= query) seg <= chk_idx;
      S_G1: begin
        ei <= e_q;
        vi <= v_q;
      end
      S_G2: begin
        // On a grid whose inner spacing differs, the query may lie below the
        // segment start, so the offset is taken as a magnitude with a sign.
        ei1     <= e_q;
        res_vel <= vi;
        dv      <= (v_q >= vi) ? v_q - vi : vi - v_q;
        dq      <= (query >= ei) ? query - ei : ei - query;
        neg     <= (v_q < vi) ^ (query < ei);
      end
      S_MUL:  prod <= 64'(dv) * 64'(dq);
      S_FIN:  res_vel <= sat_vel;
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          drift_velocity <= res_vel;
          range_code     <= res_code;
        end
      end
      default: ;
    endcase
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == S_UDIV || state == S_SDIV))
    else $error("divider finished outside a division state");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> scan_k <= pen_idx)
    else $error("segment scan ran past the penultimate breakpoint");

  a_query_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept && cmd == CMD_QUERY |=> state == S_F0)
    else $error("accepted query did not start the sequencer");

  a_below_is_zero: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && res_code == RANGE_BELOW |-> res_vel == '0)
    else $error("below-range result carries a non-zero velocity");

endmodule

### tb/tb_top.sv
// Self-checking testbench for piecewise_linear_table_interp: loads breakpoint
// tables, sweeps queries and compares each result beat with an internal predictor.
// Depends on plti_pkg and the RTL under rtl/.
module tb_top;
  import plti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    cmd_t        op;
    logic [5:0]  slot;
    logic [31:0] e_ld;
    logic [31:0] v_ld;
    logic [31:0] q;
  } beat_t;

  typedef struct {
    logic [31:0] vel;
    range_code_t code;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CountWidth-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = 1'b0;
  logic [5:0] point_index = '0;
  logic [31:0] load_energy = '0, load_velocity = '0, query_energy = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] drift_velocity;
  logic [1:0] range_code;

  piecewise_linear_table_interp uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .point_index(point_index), .load_energy(load_energy),
    .load_velocity(load_velocity), .query_energy(query_energy),
    .out_valid(out_valid), .out_stall(out_stall),
    .drift_velocity(drift_velocity), .range_code(range_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [31:0] tbl_e [64];
  logic [31:0] tbl_v [64];
  logic [6:0]  count_reg = 7'd2;

  beat_t   pending[$];
  answer_t awaited[$];
  int      errors = 0;
  bit      calm = 1'b0;       // no idling in the closing part
  bit      hold_off = 1'b0;   // long receiver stall request
  int      hold_left = 0;
  bit      in_taken = 1'b0;   // an input beat was accepted at the last rising edge

  function automatic int live_points();
    int n;
    n = count_reg;
    if (n < 2) n = 2;
    if (n > 64) n = 64;
    return n;
  endfunction

  function automatic logic [31:0] lerp(int i, logic [31:0] q);
    logic [63:0] dv, dq, mag;
    bit neg;
    logic [31:0] e0, e1, v0, v1;
    e0 = tbl_e[i]; e1 = tbl_e[i+1]; v0 = tbl_v[i]; v1 = tbl_v[i+1];
    if (e1 <= e0) return v0;
    neg = 1'b0;
    if (v1 >= v0) dv = 64'(v1 - v0); else begin dv = 64'(v0 - v1); neg = ~neg; end
    if (q >= e0) dq = 64'(q - e0); else begin dq = 64'(e0 - q); neg = ~neg; end
    mag = (dv * dq) / 64'(e1 - e0);
    if (neg) return (mag > 64'(v0)) ? 32'd0 : 32'(64'(v0) - mag);
    return (mag > 64'(32'hFFFF_FFFF - v0)) ? 32'hFFFF_FFFF : 32'(64'(v0) + mag);
  endfunction

  function automatic answer_t lookup(logic [31:0] q);
    answer_t a;
    int n, i;
    logic [31:0] stepw;
    bit uni;
    n = live_points();
    stepw = tbl_e[1] - tbl_e[0];
    uni = (tbl_e[1] > tbl_e[0]) && (tbl_e[n-1] > tbl_e[n-2]) &&
          (stepw == tbl_e[n-1] - tbl_e[n-2]);
    a.code = RANGE_INSIDE;
    if (q < tbl_e[0]) begin
      a.vel = '0; a.code = RANGE_BELOW; return a;
    end
    if (q > tbl_e[n-1]) begin
      a.vel = tbl_v[n-1]; a.code = RANGE_ABOVE; return a;
    end
    if (q == tbl_e[n-1]) begin
      a.vel = tbl_v[n-1]; return a;
    end
    if (uni) begin
      i = int'((q - tbl_e[0]) / stepw);
      if (i > n - 2) i = n - 2;
    end else begin
      i = 0;
      for (int k = 0; k + 1 < n; k++) if (tbl_e[k] <= q) i = k;
    end
    a.vel = lerp(i, q);
    return a;
  endfunction

  // Driver: offers the head of the pending queue, with random gaps.
  int gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        void'(pending.pop_front());
        if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 10);
      end
      if (gap > 0) begin
        gap = gap - 1;
        in_valid <= 1'b0;
      end else if (pending.size() > 0) begin
        in_valid <= 1'b1;
        cmd <= pending[0].op;
        point_index <= pending[0].slot;
        load_energy <= pending[0].e_ld;
        load_velocity <= pending[0].v_ld;
        query_energy <= pending[0].q;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Prediction on acceptance at the rising edge.
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      if (cmd == CMD_LOAD) begin
        tbl_e[point_index] = load_energy;
        tbl_v[point_index] = load_velocity;
      end else begin
        awaited.push_back(lookup(query_energy));
      end
    end
  end

  // Receiver stall pattern.
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
      if (hold_left > 0) hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        $error("result beat with nothing expected: velocity %h code %0d",
               drift_velocity, range_code);
        errors++;
      end else begin
        want = awaited.pop_front();
        if (drift_velocity !== want.vel) begin
          $error("drift_velocity: expected %h, actual %h", want.vel, drift_velocity);
          errors++;
        end
        if (range_code !== want.code) begin
          $error("range_code: expected %0d, actual %0d", want.code, range_code);
          errors++;
        end
      end
    end
  end

  task automatic put_load(int slot, logic [31:0] e, logic [31:0] v);
    beat_t b;
    b = '{CMD_LOAD, 6'(slot), e, v, $urandom()};
    pending.push_back(b);
  endtask

  task automatic put_query(logic [31:0] q);
    beat_t b;
    b = '{CMD_QUERY, 6'($urandom()), $urandom(), $urandom(), q};
    pending.push_back(b);
  endtask

  task automatic drain();
    while (pending.size() != 0 || awaited.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_count(int n);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= 7'(n);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Loads slots 0..count-1; the first phase loads all 64, so nothing read is
  // ever unwritten. Uniform tables have equal spacing; others are random
  // ascending or, sometimes, unsorted.
  task automatic fill_table(int style, int count);
    logic [31:0] e, stepw;
    e = $urandom_range(0, 32'h0010_0000);
    stepw = $urandom_range(1, 32'h0100_0000);
    for (int s = 0; s < count; s++) begin
      case (style)
        0: e = e + stepw;
        1: e = e + $urandom_range(0, 32'h0100_0000);
        default: e = $urandom();
      endcase
      put_load(s, e, $urandom());
    end
  endtask

  function automatic logic [31:0] near_point(int n);
    int k;
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 3))
      0: return tbl_e[k];
      1: return tbl_e[k] + $urandom_range(0, 3) - 1;
      default: return $urandom_range(0, 1) ? $urandom() :
                      tbl_e[0] + $urandom_range(0, tbl_e[n-1] - tbl_e[0]);
    endcase
  endfunction

  initial begin
    int n;
    logic [31:0] probe;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes and special cases on a two-point table.
    put_load(0, 32'h0000_1000, 32'h0000_0000);
    put_load(1, 32'h0000_2000, 32'hFFFF_FFFF);
    put_query(32'h0000_0000);
    put_query(32'h0000_1000);
    put_query(32'h0000_1800);
    put_query(32'h0000_2000);
    put_query(32'hFFFF_FFFF);
    put_load(1, 32'h0000_1000, 32'h1234_5678);   // flat segment
    put_query(32'h0000_1000);
    put_load(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_load(1, 32'h0000_0000, 32'h0000_0000);   // falling segment
    put_query(32'hFFFF_FFFF);
    put_query(32'h0000_0000);
    put_load(63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // Phases over several counts, out-of-range ones included.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: n = 64;
        1: n = 2;
        2: n = 0;
        3: n = 127;
        4: n = 1;
        5: n = 65;
        default: n = $urandom_range(2, 64);
      endcase
      set_count(n);
      count_reg = 7'(n);
      fill_table(ph % 3 == 2 ? 2 : ph % 2, ph == 0 ? 64 : live_points());
      // Predictor sees loads only when accepted; wait so near_point uses them.
      while (pending.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      if (ph == 3) hold_off = 1'b1;
      for (int j = 0; j < 16; j++) begin
        probe = near_point(live_points());
        put_query(probe);
        if ($urandom_range(0, 15) == 0) put_load($urandom_range(0, 63), probe, $urandom());
      end
      if (ph == 3) begin
        hold_left = 300;
        while (hold_left != 0) @(posedge clk);
        hold_off = 1'b0;
      end
      if (ph == 6) calm = 1'b1;
      drain();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
